FILE: hdl/tqbu_pkg.sv
// ----------------------------------------------------------------------------
// tqbu_pkg: shared types and constants of the tile quadrant upscaler
// Field widths, configuration register indexes, the job record passed from
// the front end to the back end, and the depth saturation helper.
// ----------------------------------------------------------------------------
package tqbu_pkg;

  // Texel coordinates are 8 bits, so the store is 256 x 256 texels.
  localparam int COORD_W   = 8;
  localparam int MAX_SIDE  = 2 ** COORD_W;
  localparam int MAX_DEPTH = 15;
  localparam int DEPTH_W   = 4;
  localparam int QIDX_W    = 15;
  localparam int SIZE_W    = 9;
  localparam int CHAN_W    = 8;
  localparam int NUM_CHAN  = 4;
  localparam int TEXEL_W   = CHAN_W * NUM_CHAN;

  // Four parity banks, each holding every second row and column.
  localparam int BANK_AW   = 2 * (COORD_W - 1);

  // Weights are in units of 2^-(d+1) and reach 2^(d+1) itself.
  localparam int WT_W      = MAX_DEPTH + 2;
  localparam int PROD_W    = QIDX_W + COORD_W;
  localparam int NUM_W     = PROD_W + 3;
  localparam int HSUM_W    = CHAN_W + WT_W - 1;
  localparam int VSUM_W    = HSUM_W + WT_W - 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = QIDX_W;

  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAD_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAD_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd4;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth_levels;
    logic [QIDX_W-1:0]  quadrant_x;
    logic [QIDX_W-1:0]  quadrant_y;
    logic [SIZE_W-1:0]  tile_width;
    logic [SIZE_W-1:0]  tile_height;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] base;
    logic [WT_W-1:0]    wt;
  } axis_t;

  typedef struct packed {
    logic               is_load;
    logic               bad;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [TEXEL_W-1:0] texel;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [WT_W-1:0]    fx;
    logic [WT_W-1:0]    fy;
  } job_t;

  function automatic logic [DEPTH_W-1:0] sat_depth(input logic [DEPTH_W-1:0] d);
    return (d > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH) : d;
  endfunction

endpackage

FILE: hdl/tqbu_in_if.sv
// ----------------------------------------------------------------------------
// tqbu_in_if: request channel of the tile quadrant upscaler
// Valid/ready channel carrying load and sample requests.
// ----------------------------------------------------------------------------
interface tqbu_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] col;
  logic [7:0] row;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic [7:0] in_alpha;

  modport source (
    output valid, req_type, col, row, in_red, in_green, in_blue, in_alpha,
    input  ready
  );
  modport sink (
    input  valid, req_type, col, row, in_red, in_green, in_blue, in_alpha,
    output ready
  );
endinterface

FILE: hdl/tqbu_out_if.sv
// ----------------------------------------------------------------------------
// tqbu_out_if: result channel of the tile quadrant upscaler
// Valid/ready channel carrying one blended output texel per sample.
// ----------------------------------------------------------------------------
interface tqbu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       bad_request;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha, bad_request,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha, bad_request,
    output ready
  );
endinterface

FILE: hdl/tqbu_front.sv
// ----------------------------------------------------------------------------
// tqbu_front: request front end
// Accepts requests, flags out-of-range samples, forms the quadrant offsets
// in one registered multiply and then works out base texel and weight per
// axis before handing the job to the queue.
// ----------------------------------------------------------------------------
module tqbu_front (
  input  logic            clk,
  input  logic            rst_n,
  input  tqbu_pkg::cfg_t  cfg,
  tqbu_in_if.sink         in_ch,
  input  logic            fifo_full,
  output logic            push,
  output tqbu_pkg::job_t  push_job
);
  import tqbu_pkg::*;

  logic               f1_valid_r;
  logic               f1_load_r;
  logic               f1_bad_r;
  logic [COORD_W-1:0] f1_col_r;
  logic [COORD_W-1:0] f1_row_r;
  logic [TEXEL_W-1:0] f1_texel_r;
  logic [PROD_W-1:0]  f1_px_r;
  logic [PROD_W-1:0]  f1_py_r;

  logic [SIZE_W-1:0]  w_sat;
  logic [SIZE_W-1:0]  h_sat;
  logic [DEPTH_W-1:0] d_sat;
  logic               advance;
  logic               bad_nxt;
  axis_t              ax_x;
  axis_t              ax_y;

  // Base texel and weight along one axis for sample position
  // (p + i + 0.5) / 2^d - 0.5, all held in units of 2^-(d+1).
  function automatic axis_t axis_pos(input logic [PROD_W-1:0]  p,
                                     input logic [COORD_W-1:0] i,
                                     input logic [SIZE_W-1:0]  n,
                                     input logic [DEPTH_W-1:0] d);
    logic [PROD_W:0]          pi;
    logic [DEPTH_W:0]         shamt;
    logic [WT_W-1:0]          den;
    logic signed [NUM_W-1:0]  num;
    logic signed [NUM_W-1:0]  hi;
    logic signed [NUM_W-1:0]  c;
    logic signed [NUM_W-1:0]  t;
    logic [NUM_W-1:0]         cq;
    logic [SIZE_W-1:0]        b;
    axis_t                    res;
    pi    = (PROD_W + 1)'(p) + (PROD_W + 1)'(i);
    shamt = {1'b0, d} + (DEPTH_W + 1)'(1);
    den   = WT_W'(1) << shamt;
    num   = $signed({1'b0, pi, 1'b1}) - $signed(NUM_W'(1) << d);
    hi    = $signed(NUM_W'(n - SIZE_W'(1)) << shamt);
    if (num < 0) begin
      c = '0;
    end else if (num > hi) begin
      c = hi;
    end else begin
      c = num;
    end
    cq = NUM_W'(c) >> shamt;
    b  = cq[SIZE_W-1:0];
    if (b > n - SIZE_W'(2)) begin
      b = n - SIZE_W'(2);
    end
    t = num - $signed(NUM_W'(b) << shamt);
    res.base = b[COORD_W-1:0];
    if (t < 0) begin
      res.wt = '0;
    end else if (t > $signed(NUM_W'(den))) begin
      res.wt = den;
    end else begin
      res.wt = t[WT_W-1:0];
    end
    return res;
  endfunction

  assign w_sat = (cfg.tile_width > SIZE_W'(MAX_SIDE)) ? SIZE_W'(MAX_SIDE) : cfg.tile_width;
  assign h_sat = (cfg.tile_height > SIZE_W'(MAX_SIDE)) ? SIZE_W'(MAX_SIDE) : cfg.tile_height;
  assign d_sat = sat_depth(cfg.depth_levels);

  assign advance     = !(f1_valid_r && fifo_full);
  assign in_ch.ready = advance;

  assign bad_nxt = (w_sat < SIZE_W'(2)) || (h_sat < SIZE_W'(2)) ||
                   (SIZE_W'(in_ch.col) >= w_sat) || (SIZE_W'(in_ch.row) >= h_sat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (advance) begin
      f1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_ch.valid) begin
      f1_load_r  <= (in_ch.req_type == REQ_LOAD);
      f1_bad_r   <= (in_ch.req_type == REQ_SAMPLE) && bad_nxt;
      f1_col_r   <= in_ch.col;
      f1_row_r   <= in_ch.row;
      f1_texel_r <= {in_ch.in_alpha, in_ch.in_blue, in_ch.in_green, in_ch.in_red};
      f1_px_r    <= PROD_W'(PROD_W'(cfg.quadrant_x) * PROD_W'(w_sat));
      f1_py_r    <= PROD_W'(PROD_W'(cfg.quadrant_y) * PROD_W'(h_sat));
    end
  end

  assign ax_x = axis_pos(f1_px_r, f1_col_r, w_sat, d_sat);
  assign ax_y = axis_pos(f1_py_r, f1_row_r, h_sat, d_sat);

  assign push = f1_valid_r && !fifo_full;

  always_comb begin
    push_job.is_load = f1_load_r;
    push_job.bad     = f1_bad_r;
    push_job.col     = f1_col_r;
    push_job.row     = f1_row_r;
    push_job.texel   = f1_texel_r;
    push_job.x0      = ax_x.base;
    push_job.y0      = ax_y.base;
    push_job.fx      = ax_x.wt;
    push_job.fy      = ax_y.wt;
  end

endmodule

FILE: hdl/tqbu_fifo.sv
// ----------------------------------------------------------------------------
// tqbu_fifo: job queue between front end and back end
// Small register queue so that either side can stall on its own.
// ----------------------------------------------------------------------------
module tqbu_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tqbu_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output tqbu_pkg::job_t head
);
  import tqbu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("job queue read while empty");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("job queue count lost a write");

endmodule

FILE: hdl/tqbu_back.sv
// ----------------------------------------------------------------------------
// tqbu_back: texel store and blending back end
// Four parity-banked texel memories give all four neighbours of a sample in
// one read. Loads write one bank. Samples pass through a horizontal blend,
// a vertical blend and a rounding stage into the output register.
// ----------------------------------------------------------------------------
module tqbu_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [tqbu_pkg::DEPTH_W-1:0]   depth_levels,
  input  logic                           fifo_empty,
  output logic                           pop,
  input  tqbu_pkg::job_t                 head,
  tqbu_out_if.source                     out_ch
);
  import tqbu_pkg::*;

  localparam int PH_W = CHAN_W + WT_W;
  localparam int PV_W = HSUM_W + WT_W;
  localparam int BANK_DEPTH = 2 ** BANK_AW;

  logic [DEPTH_W-1:0]   d_sat;
  logic [WT_W-1:0]      den;
  logic [5:0]           rshift;
  logic [VSUM_W-1:0]    half;
  logic                 stall;
  logic                 advance;
  logic                 wr_en;
  logic                 rd_en;
  logic [1:0]           wr_bank;
  logic [BANK_AW-1:0]   wr_addr;
  logic [BANK_AW-1:0]   rd_addr [NUM_CHAN];

  logic [TEXEL_W-1:0]   rdata_r [NUM_CHAN];
  logic                 b1_valid_r;
  logic                 b1_bad_r;
  logic                 b1_xp_r;
  logic                 b1_yp_r;
  logic [WT_W-1:0]      b1_fx_r;
  logic [WT_W-1:0]      b1_fy_r;

  logic [TEXEL_W-1:0]   tex_a;
  logic [TEXEL_W-1:0]   tex_b;
  logic [TEXEL_W-1:0]   tex_c;
  logic [TEXEL_W-1:0]   tex_e;
  logic [HSUM_W-1:0]    top_nxt [NUM_CHAN];
  logic [HSUM_W-1:0]    bot_nxt [NUM_CHAN];

  logic                 b2_valid_r;
  logic                 b2_bad_r;
  logic [WT_W-1:0]      b2_fy_r;
  logic [HSUM_W-1:0]    b2_top_r [NUM_CHAN];
  logic [HSUM_W-1:0]    b2_bot_r [NUM_CHAN];
  logic [VSUM_W-1:0]    sum_nxt  [NUM_CHAN];

  logic                 b3_valid_r;
  logic                 b3_bad_r;
  logic [VSUM_W-1:0]    b3_sum_r [NUM_CHAN];
  logic [CHAN_W-1:0]    chan_nxt [NUM_CHAN];

  logic                 out_valid_r;
  logic                 out_bad_r;
  logic [CHAN_W-1:0]    out_chan_r [NUM_CHAN];

  assign d_sat  = sat_depth(depth_levels);
  assign den    = WT_W'(1) << ({1'b0, d_sat} + (DEPTH_W + 1)'(1));
  assign rshift = {1'b0, d_sat, 1'b0} + 6'd2;
  assign half   = VSUM_W'(1) << ({1'b0, d_sat, 1'b0} + 6'd1);

  // The whole back end moves together; it holds only while a finished
  // result waits in the output register.
  assign stall   = out_valid_r && !out_ch.ready;
  assign advance = !stall;
  assign pop     = advance && !fifo_empty;

  assign wr_en   = pop && head.is_load;
  assign rd_en   = pop && !head.is_load && !head.bad;
  assign wr_bank = {head.row[0], head.col[0]};
  assign wr_addr = {head.row[COORD_W-1:1], head.col[COORD_W-1:1]};

  // Bank index: upper bit is row parity, lower bit column parity.
  always_comb begin
    logic [COORD_W-1:0] rrow;
    logic [COORD_W-1:0] rcol;
    for (int k = 0; k < NUM_CHAN; k++) begin
      rrow = (head.y0[0] == k[1]) ? head.y0 : head.y0 + COORD_W'(1);
      rcol = (head.x0[0] == k[0]) ? head.x0 : head.x0 + COORD_W'(1);
      rd_addr[k] = {rrow[COORD_W-1:1], rcol[COORD_W-1:1]};
    end
  end

  for (genvar k = 0; k < NUM_CHAN; k++) begin : g_bank
    logic [TEXEL_W-1:0] bank_mem [BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == 2'(k))) begin
        bank_mem[wr_addr] <= head.texel;
      end
      if (rd_en) begin
        rdata_r[k] <= bank_mem[rd_addr[k]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      b2_valid_r  <= 1'b0;
      b3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      b1_valid_r  <= pop && !head.is_load;
      b2_valid_r  <= b1_valid_r;
      b3_valid_r  <= b2_valid_r;
      out_valid_r <= b3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_bad_r <= head.bad;
      b1_xp_r  <= head.x0[0];
      b1_yp_r  <= head.y0[0];
      b1_fx_r  <= head.fx;
      b1_fy_r  <= head.fy;
    end
  end

  assign tex_a = rdata_r[{b1_yp_r, b1_xp_r}];
  assign tex_b = rdata_r[{b1_yp_r, !b1_xp_r}];
  assign tex_c = rdata_r[{!b1_yp_r, b1_xp_r}];
  assign tex_e = rdata_r[{!b1_yp_r, !b1_xp_r}];

  always_comb begin
    logic [PH_W-1:0] p0;
    logic [PH_W-1:0] p1;
    logic [PH_W-1:0] p2;
    logic [PH_W-1:0] p3;
    logic [PH_W-1:0] s0;
    logic [PH_W-1:0] s1;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      p0 = PH_W'(tex_a[ch*CHAN_W +: CHAN_W]) * PH_W'(den - b1_fx_r);
      p1 = PH_W'(tex_b[ch*CHAN_W +: CHAN_W]) * PH_W'(b1_fx_r);
      p2 = PH_W'(tex_c[ch*CHAN_W +: CHAN_W]) * PH_W'(den - b1_fx_r);
      p3 = PH_W'(tex_e[ch*CHAN_W +: CHAN_W]) * PH_W'(b1_fx_r);
      s0 = p0 + p1;
      s1 = p2 + p3;
      top_nxt[ch] = s0[HSUM_W-1:0];
      bot_nxt[ch] = s1[HSUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b2_bad_r <= b1_bad_r;
      b2_fy_r  <= b1_fy_r;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        b2_top_r[ch] <= top_nxt[ch];
        b2_bot_r[ch] <= bot_nxt[ch];
      end
    end
  end

  always_comb begin
    logic [PV_W-1:0] q0;
    logic [PV_W-1:0] q1;
    logic [PV_W-1:0] qs;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      q0 = PV_W'(b2_top_r[ch]) * PV_W'(den - b2_fy_r);
      q1 = PV_W'(b2_bot_r[ch]) * PV_W'(b2_fy_r);
      qs = q0 + q1;
      sum_nxt[ch] = qs[VSUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b3_bad_r <= b2_bad_r;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        b3_sum_r[ch] <= sum_nxt[ch];
      end
    end
  end

  // Round half up, drop the 2(d+1) fraction bits and saturate to 8 bits; rejected samples give zero.
  always_comb begin
    logic [VSUM_W-1:0] rs;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      rs = (b3_sum_r[ch] + half) >> rshift;
      if (b3_bad_r) begin
        chan_nxt[ch] = '0;
      end else if (|rs[VSUM_W-1:CHAN_W]) begin
        chan_nxt[ch] = '1;
      end else begin
        chan_nxt[ch] = rs[CHAN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_bad_r <= b3_bad_r;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        out_chan_r[ch] <= chan_nxt[ch];
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_red     = out_chan_r[0];
  assign out_ch.out_green   = out_chan_r[1];
  assign out_ch.out_blue    = out_chan_r[2];
  assign out_ch.out_alpha   = out_chan_r[3];
  assign out_ch.bad_request = out_bad_r;

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.is_load) |=> !b1_valid_r)
    else $error("a texel load entered the blend pipeline");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |->
      (out_chan_r[0] == '0 && out_chan_r[1] == '0 &&
       out_chan_r[2] == '0 && out_chan_r[3] == '0))
    else $error("rejected sample carries non-zero channels");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> (b3_valid_r == $past(b3_valid_r) && b3_sum_r[0] == $past(b3_sum_r[0])))
    else $error("blend pipeline moved while the output was stalled");

endmodule

FILE: hdl/tile_quadrant_bilinear_upscale_core.sv
// ----------------------------------------------------------------------------
// tile_quadrant_bilinear_upscale_core: bilinear quadrant upscaler, RGBA8
// A sample passes front-end, queue, bank read, blend and output registers.
// Throughput: one load or sample request per cycle while the job queue is
// not full, set by the four parity-banked texel memories that each take one
// access per cycle. Loads produce no result; the job queue lets input and
// output stall apart. Reset clears the pipeline and queue and restores the
// configuration registers; texel store contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module tile_quadrant_bilinear_upscale_core #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tqbu_in_if.sink                         in_ch,
  tqbu_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [tqbu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tqbu_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tqbu_pkg::*;

  cfg_t cfg_r;
  logic fifo_full;
  logic fifo_empty;
  logic push;
  logic pop;
  job_t push_job;
  job_t head_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_levels <= DEPTH_W'(1);
      cfg_r.quadrant_x   <= '0;
      cfg_r.quadrant_y   <= '0;
      cfg_r.tile_width   <= SIZE_W'(MAX_SIDE);
      cfg_r.tile_height  <= SIZE_W'(MAX_SIDE);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEPTH:  cfg_r.depth_levels <= cfg_wdata[DEPTH_W-1:0];
        CFG_QUAD_X: cfg_r.quadrant_x   <= cfg_wdata[QIDX_W-1:0];
        CFG_QUAD_Y: cfg_r.quadrant_y   <= cfg_wdata[QIDX_W-1:0];
        CFG_WIDTH:  cfg_r.tile_width   <= cfg_wdata[SIZE_W-1:0];
        CFG_HEIGHT: cfg_r.tile_height  <= cfg_wdata[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tqbu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .fifo_full (fifo_full),
    .push      (push),
    .push_job  (push_job)
  );

  tqbu_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (fifo_full),
    .pop      (pop),
    .empty    (fifo_empty),
    .head     (head_job)
  );

  tqbu_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .depth_levels (cfg_r.depth_levels),
    .fifo_empty   (fifo_empty),
    .pop          (pop),
    .head         (head_job),
    .out_ch       (out_ch)
  );

endmodule

FILE: bench/tb_tile_quadrant_bilinear_upscale_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tile_quadrant_bilinear_upscale_core: self-checking bench for the upscaler
// Sends load and sample transactions in random bursts while the result side
// stalls on its own pattern. Every output texel is checked against a fixed
// value or a bit-exact fixed-point quadrant resampling model kept in the bench.
// ----------------------------------------------------------------------------
module tb_tile_quadrant_bilinear_upscale_core;
  import tqbu_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS  = 85;
  localparam int NUM_STEPS    = 33;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              bad;
  } texel_result_t;

  // The texel is packed as in the store: red in the low byte, alpha on top.
  typedef struct packed {
    logic               req_type;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [TEXEL_W-1:0] texel;
  } request_t;

  typedef enum logic [1:0] {STEP_LOAD, STEP_SAMPLE, STEP_REG} step_kind_t;
  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_EVERY_THIRD, RX_LONG_STALL} stall_mode_t;

  typedef struct {
    step_kind_t           kind;
    logic [COORD_W-1:0]   col;
    logic [COORD_W-1:0]   row;
    logic [TEXEL_W-1:0]   texel;
    logic [CFG_IDX_W-1:0] reg_idx;
    int                   reg_val;
    bit                   typed;
    texel_result_t        want;
  } step_t;

  localparam texel_result_t NO_RESULT    = '0;
  localparam texel_result_t REJECTED     = '{8'd0, 8'd0, 8'd0, 8'd0, 1'b1};
  // With zero weights on both axes the origin sample is texel (0,0) unchanged.
  localparam texel_result_t ORIGIN_TEXEL = '{8'hff, 8'h00, 8'h80, 8'h01, 1'b0};

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tqbu_in_if  in_if ();
  tqbu_out_if out_if ();

  tile_quadrant_bilinear_upscale_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  cfg_t          bench_cfg = '{4'd1, 15'd0, 15'd0, 9'd256, 9'd256};
  logic [31:0]   texel_mirror [0:MAX_SIDE*MAX_SIDE-1];
  bit            loaded_map [0:MAX_SIDE*MAX_SIDE-1];
  texel_result_t texels_due [$];

  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned loads_sent = 0;
  int unsigned texels_checked = 0;
  int unsigned settings_used = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;

  step_t directed_steps [0:NUM_STEPS-1] = '{
    '{STEP_LOAD,   8'd0,   8'd0,   32'h0180_00ff, CFG_DEPTH,  0,     1'b0, NO_RESULT},
    '{STEP_LOAD,   8'd1,   8'd0,   32'hfe7f_ff00, CFG_DEPTH,  0,     1'b0, NO_RESULT},
    '{STEP_LOAD,   8'd0,   8'd1,   32'h7856_3412, CFG_DEPTH,  0,     1'b0, NO_RESULT},
    '{STEP_LOAD,   8'd1,   8'd1,   32'hffff_ffff, CFG_DEPTH,  0,     1'b0, NO_RESULT},
    '{STEP_SAMPLE, 8'd0,   8'd0,   32'hffff_ffff, CFG_DEPTH,  0,     1'b1, ORIGIN_TEXEL},
    '{STEP_SAMPLE, 8'd1,   8'd1,   32'h0000_0000, CFG_DEPTH,  0,     1'b0, NO_RESULT},
    '{STEP_LOAD,   8'd255, 8'd255, 32'hffff_ffff, CFG_DEPTH,  0,     1'b0, NO_RESULT},
    '{STEP_LOAD,   8'd255, 8'd0,   32'h0000_0000, CFG_DEPTH,  0,     1'b0, NO_RESULT},
    '{STEP_LOAD,   8'd0,   8'd255, 32'hffff_ffff, CFG_DEPTH,  0,     1'b0, NO_RESULT},
    '{STEP_SAMPLE, 8'd255, 8'd255, 32'h0000_0000, CFG_DEPTH,  0,     1'b0, NO_RESULT},
    '{STEP_SAMPLE, 8'd0,   8'd255, 32'h0000_0000, CFG_DEPTH,  0,     1'b0, NO_RESULT},
    '{STEP_REG,    8'd0,   8'd0,   32'h0000_0000, CFG_WIDTH,  2,     1'b0, NO_RESULT},
    '{STEP_REG,    8'd0,   8'd0,   32'h0000_0000, CFG_HEIGHT, 2,     1'b0, NO_RESULT},
    '{STEP_SAMPLE, 8'd2,   8'd0,   32'h0000_0000, CFG_DEPTH,  0,     1'b1, REJECTED},
    '{STEP_SAMPLE, 8'd0,   8'd2,   32'h0000_0000, CFG_DEPTH,  0,     1'b1, REJECTED},
    '{STEP_SAMPLE, 8'd255, 8'd255, 32'hffff_ffff, CFG_DEPTH,  0,     1'b1, REJECTED},
    '{STEP_LOAD,   8'd200, 8'd100, 32'ha5a5_5a5a, CFG_DEPTH,  0,     1'b0, NO_RESULT},
    '{STEP_SAMPLE, 8'd1,   8'd1,   32'h0000_0000, CFG_DEPTH,  0,     1'b0, NO_RESULT},
    '{STEP_REG,    8'd0,   8'd0,   32'h0000_0000, CFG_WIDTH,  1,     1'b0, NO_RESULT},
    '{STEP_SAMPLE, 8'd0,   8'd0,   32'h0000_0000, CFG_DEPTH,  0,     1'b1, REJECTED},
    '{STEP_REG,    8'd0,   8'd0,   32'h0000_0000, CFG_WIDTH,  300,   1'b0, NO_RESULT},
    '{STEP_REG,    8'd0,   8'd0,   32'h0000_0000, CFG_HEIGHT, 511,   1'b0, NO_RESULT},
    '{STEP_REG,    8'd0,   8'd0,   32'h0000_0000, CFG_DEPTH,  0,     1'b0, NO_RESULT},
    '{STEP_SAMPLE, 8'd10,  8'd10,  32'h0000_0000, CFG_DEPTH,  0,     1'b0, NO_RESULT},
    '{STEP_SAMPLE, 8'd255, 8'd255, 32'h0000_0000, CFG_DEPTH,  0,     1'b0, NO_RESULT},
    '{STEP_REG,    8'd0,   8'd0,   32'h0000_0000, CFG_DEPTH,  15,    1'b0, NO_RESULT},
    '{STEP_REG,    8'd0,   8'd0,   32'h0000_0000, CFG_QUAD_X, 32767, 1'b0, NO_RESULT},
    '{STEP_REG,    8'd0,   8'd0,   32'h0000_0000, CFG_QUAD_Y, 32767, 1'b0, NO_RESULT},
    '{STEP_SAMPLE, 8'd255, 8'd0,   32'h0000_0000, CFG_DEPTH,  0,     1'b0, NO_RESULT},
    '{STEP_SAMPLE, 8'd0,   8'd255, 32'h0000_0000, CFG_DEPTH,  0,     1'b0, NO_RESULT},
    '{STEP_REG,    8'd0,   8'd0,   32'h0000_0000, CFG_QUAD_X, 0,     1'b0, NO_RESULT},
    '{STEP_SAMPLE, 8'd128, 8'd64,  32'h0000_0000, CFG_DEPTH,  0,     1'b0, NO_RESULT},
    '{STEP_REG,    8'd0,   8'd0,   32'h0000_0000, CFG_QUAD_Y, 0,     1'b0, NO_RESULT}
  };

  // Base texel and weight along one axis; the weight is in units of 2^-(d+1).
  function automatic void locate_axis(input longint q, input longint n, input longint i,
                                      input int d, output longint base, output longint wt);
    longint den, num, c;
    den = longint'(1) << (d + 1);
    num = 2 * (q * n + i) + 1 - (longint'(1) << d);
    c = (num < 0) ? 0 : ((num > (n - 1) * den) ? (n - 1) * den : num);
    base = c / den;
    if (base > n - 2) base = n - 2;
    wt = num - base * den;
    if (wt < 0) wt = 0;
    if (wt > den) wt = den;
  endfunction

  // Returns 0 when the sample is rejected, otherwise the top-left neighbour
  // and the two weights.
  function automatic bit sample_footprint(input logic [COORD_W-1:0] col, row,
                                          output longint x0, y0, fx, fy);
    longint w, h;
    w = (bench_cfg.tile_width > MAX_SIDE) ? MAX_SIDE : bench_cfg.tile_width;
    h = (bench_cfg.tile_height > MAX_SIDE) ? MAX_SIDE : bench_cfg.tile_height;
    x0 = 0;
    y0 = 0;
    fx = 0;
    fy = 0;
    if (w < 2 || h < 2 || col >= w || row >= h) return 1'b0;
    locate_axis(bench_cfg.quadrant_x, w, col, sat_depth(bench_cfg.depth_levels), x0, fx);
    locate_axis(bench_cfg.quadrant_y, h, row, sat_depth(bench_cfg.depth_levels), y0, fy);
    return 1'b1;
  endfunction

  function automatic logic [CHAN_W-1:0] mix_channel(input longint unsigned a, b, c, e,
                                                    input longint unsigned fx, fy,
                                                    input int d);
    longint unsigned den, top, bot, acc;
    int sh;
    den = 64'd1 << (d + 1);
    sh = 2 * d + 2;
    top = a * (den - fx) + b * fx;
    bot = c * (den - fx) + e * fx;
    // Exact blend, then round half up.
    acc = (top * (den - fy) + bot * fy + (64'd1 << (sh - 1))) >> sh;
    return (acc > 255) ? 8'd255 : acc[CHAN_W-1:0];
  endfunction

  function automatic texel_result_t blend_output_texel(input logic [COORD_W-1:0] col, row);
    texel_result_t res;
    longint x0, y0, fx, fy;
    logic [TEXEL_W-1:0] t00, t01, t10, t11;
    int d;
    if (!sample_footprint(col, row, x0, y0, fx, fy)) return REJECTED;
    d = sat_depth(bench_cfg.depth_levels);
    t00 = texel_mirror[y0 * MAX_SIDE + x0];
    t01 = texel_mirror[y0 * MAX_SIDE + x0 + 1];
    t10 = texel_mirror[(y0 + 1) * MAX_SIDE + x0];
    t11 = texel_mirror[(y0 + 1) * MAX_SIDE + x0 + 1];
    res.red   = mix_channel(t00[7:0], t01[7:0], t10[7:0], t11[7:0], fx, fy, d);
    res.green = mix_channel(t00[15:8], t01[15:8], t10[15:8], t11[15:8], fx, fy, d);
    res.blue  = mix_channel(t00[23:16], t01[23:16], t10[23:16], t11[23:16], fx, fy, d);
    res.alpha = mix_channel(t00[31:24], t01[31:24], t10[31:24], t11[31:24], fx, fy, d);
    res.bad   = 1'b0;
    return res;
  endfunction

  task automatic send_request(input request_t rq, input bit typed, input texel_result_t want);
    int unsigned gap;
    texel_result_t due;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
    burst_left--;
    in_if.valid    <= 1'b1;
    in_if.req_type <= rq.req_type;
    in_if.col      <= rq.col;
    in_if.row      <= rq.row;
    in_if.in_red   <= rq.texel[7:0];
    in_if.in_green <= rq.texel[15:8];
    in_if.in_blue  <= rq.texel[23:16];
    in_if.in_alpha <= rq.texel[31:24];
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    // The transaction has been accepted: update the mirror or queue the result.
    items_sent++;
    if (rq.req_type == REQ_LOAD) begin
      texel_mirror[{rq.row, rq.col}] = rq.texel;
      loads_sent++;
    end else begin
      due = typed ? want : blend_output_texel(rq.col, rq.row);
      texels_due = {texels_due, due};
    end
  endtask

  task automatic issue_load(input logic [COORD_W-1:0] col, row, input logic [TEXEL_W-1:0] texel);
    loaded_map[{row, col}] = 1'b1;
    send_request('{REQ_LOAD, col, row, texel}, 1'b0, NO_RESULT);
  endtask

  // The store is undefined until written, so any neighbour not loaded yet is
  // loaded with random content just before the sample.
  task automatic issue_sample(input logic [COORD_W-1:0] col, row, input bit typed,
                              input texel_result_t want);
    longint x0, y0, fx, fy;
    if (sample_footprint(col, row, x0, y0, fx, fy)) begin
      for (int k = 0; k < 4; k++) begin
        if (!loaded_map[(y0 + k / 2) * MAX_SIDE + x0 + k % 2])
          issue_load(COORD_W'(x0 + k % 2), COORD_W'(y0 + k / 2), $urandom);
      end
    end
    send_request('{REQ_SAMPLE, col, row, $urandom}, typed, want);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (texels_due.size() != 0) @(posedge clk);
    // Loads give no result and may still be in the pipeline.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    case (idx)
      CFG_DEPTH:  bench_cfg.depth_levels = DEPTH_W'(val);
      CFG_QUAD_X: bench_cfg.quadrant_x   = QIDX_W'(val);
      CFG_QUAD_Y: bench_cfg.quadrant_y   = QIDX_W'(val);
      CFG_WIDTH:  bench_cfg.tile_width   = SIZE_W'(val);
      CFG_HEIGHT: bench_cfg.tile_height  = SIZE_W'(val);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic run_phase(input int d, qx, qy, w, h);
    int unsigned stop, pick;
    int ew, eh;
    settle();
    write_reg(CFG_DEPTH, d);
    write_reg(CFG_QUAD_X, qx);
    write_reg(CFG_QUAD_Y, qy);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    cfg_we <= 1'b0;
    settings_used++;
    ew = (w > MAX_SIDE) ? MAX_SIDE : w;
    eh = (h > MAX_SIDE) ? MAX_SIDE : h;
    stop = items_sent + PHASE_ITEMS;
    // Mostly loads and samples inside the tile; the rest lands anywhere.
    while (items_sent < stop) begin
      pick = $urandom_range(0, 19);
      if (pick < 5 && ew > 0 && eh > 0)
        issue_load(COORD_W'($urandom_range(0, ew - 1)), COORD_W'($urandom_range(0, eh - 1)),
                   $urandom);
      else if (pick < 7)
        issue_load(COORD_W'($urandom_range(0, 255)), COORD_W'($urandom_range(0, 255)),
                   $urandom);
      else if (pick < 17 && ew > 0 && eh > 0)
        issue_sample(COORD_W'($urandom_range(0, ew - 1)), COORD_W'($urandom_range(0, eh - 1)),
                     1'b0, NO_RESULT);
      else
        issue_sample(COORD_W'($urandom_range(0, 255)), COORD_W'($urandom_range(0, 255)),
                     1'b0, NO_RESULT);
    end
  endtask

  function automatic void report_mismatch(input string what, input texel_result_t want,
                                          input texel_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected rgba %h %h %h %h bad %b, got rgba %h %h %h %h bad %b",
               $realtime, what, want.red, want.green, want.blue, want.alpha, want.bad,
               got.red, got.green, got.blue, got.alpha, got.bad);
  endfunction

  // Result channel: ready follows a pattern picked at random from four modes.
  initial begin
    stall_mode_t mode;
    int unsigned mode_left;
    out_if.ready = 1'b0;
    mode = RX_OPEN;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 200);
      end
      mode_left--;
      case (mode)
        RX_OPEN:        out_if.ready <= 1'b1;
        RX_RANDOM:      out_if.ready <= ($urandom_range(0, 3) != 0);
        RX_EVERY_THIRD: out_if.ready <= (mode_left % 3 != 0);
        default:        out_if.ready <= (mode_left % 16 >= 12);
      endcase
    end
  end

  always @(posedge clk) begin
    texel_result_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.out_red, out_if.out_green, out_if.out_blue, out_if.out_alpha,
              out_if.bad_request};
      if (texels_due.size() == 0) begin
        report_mismatch("output texel with none outstanding", NO_RESULT, got);
      end else begin
        want = texels_due.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.alpha !== want.alpha || got.bad !== want.bad)
          report_mismatch("output texel mismatch", want, got);
      end
      texels_checked++;
    end
  end

  // Watchdog: any accepted transaction on either channel resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Stalled for %0d cycles with %0d texels outstanding.", idle_cycles,
               texels_due.size());
      $display("** tile_quadrant_bilinear_upscale_core: FAILED **");
      $finish;
    end
  end

  initial begin
    int d, qmax, qx, qy;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_DEPTH;
    cfg_wdata      = '0;
    in_if.valid    = 1'b0;
    in_if.req_type = REQ_LOAD;
    in_if.col      = '0;
    in_if.row      = '0;
    in_if.in_red   = '0;
    in_if.in_green = '0;
    in_if.in_blue  = '0;
    in_if.in_alpha = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, starting from the reset settings.
    settings_used++;
    foreach (directed_steps[k]) begin
      case (directed_steps[k].kind)
        STEP_LOAD:
          issue_load(directed_steps[k].col, directed_steps[k].row, directed_steps[k].texel);
        STEP_SAMPLE:
          issue_sample(directed_steps[k].col, directed_steps[k].row, directed_steps[k].typed,
                       directed_steps[k].want);
        default: begin
          settle();
          write_reg(directed_steps[k].reg_idx, directed_steps[k].reg_val);
          cfg_we <= 1'b0;
        end
      endcase
    end

    // Fixed settings covering the register extremes, then random ones.
    run_phase(1, 0, 1, 256, 256);
    run_phase(0, 0, 0, 16, 16);
    run_phase(2, 3, 1, 37, 5);
    run_phase(15, 32767, 0, 256, 256);
    run_phase(3, 7, 7, 2, 2);
    run_phase(4, 5, 9, 511, 300);
    run_phase(1, 0, 0, 1, 100);
    run_phase(6, 63, 63, 200, 0);
    run_phase(15, 16384, 32767, 3, 255);
    run_phase(5, 40, 2, 256, 2);
    repeat (4) begin
      d = $urandom_range(0, 15);
      qmax = (1 << d) - 1;
      qx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, qmax);
      qy = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, qmax);
      run_phase(d, qx, qy, $urandom_range(2, 256), $urandom_range(2, 256));
    end
    settle();

    $display("Sent %0d requests (%0d loads) under %0d register settings.", items_sent,
             loads_sent, settings_used);
    $display("Checked %0d output texels, %0d mismatches.", texels_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("** tile_quadrant_bilinear_upscale_core: PASSED **");
    end else begin
      $display("** tile_quadrant_bilinear_upscale_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/tqbu_pkg.sv
hdl/tqbu_in_if.sv
hdl/tqbu_out_if.sv
hdl/tqbu_front.sv
hdl/tqbu_fifo.sv
hdl/tqbu_back.sv
hdl/tile_quadrant_bilinear_upscale_core.sv
bench/tb_tile_quadrant_bilinear_upscale_core.sv
